// ===== rtl/assert_macros.svh =====
// assertion macros for the station table checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while the active-low reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/stt_pkg.sv =====
// package for the station table: sizes, op and event codes, request,
// result and entry types; no dependencies
`default_nettype none
package stt_pkg;

  localparam int ENTRIES = 32;
  localparam int PORTS   = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [2:0] OP_CREATE     = 3'd0;
  localparam logic [2:0] OP_UPD_MAC    = 3'd1;
  localparam logic [2:0] OP_UPD_ID     = 3'd2;
  localparam logic [2:0] OP_TICK       = 3'd3;
  localparam logic [2:0] OP_FLUSH_ALL  = 3'd4;
  localparam logic [2:0] OP_FLUSH_PORT = 3'd5;
  localparam logic [2:0] OP_READ_SLOT  = 3'd6;

  localparam logic [2:0] EV_ADD    = 3'd0;
  localparam logic [2:0] EV_DEL    = 3'd1;
  localparam logic [2:0] EV_CHANGE = 3'd2;
  localparam logic [2:0] EV_READ   = 3'd3;
  localparam logic [2:0] EV_FULL   = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [47:0] mac_addr;
    logic [31:0] ip_addr;
    logic [3:0]  port;
    logic [31:0] rx_add;
    logic [31:0] tx_add;
    logic        alive;
    logic [31:0] entry_id;
    logic [4:0]  slot;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [47:0] ev_mac;
    logic [31:0] ev_ip;
    logic [3:0]  ev_port;
    logic [31:0] ev_id;
    logic [63:0] rx_total;
    logic [63:0] tx_total;
    logic        slot_valid;
    logic        last;
  } out_res_t;

  typedef struct packed {
    logic        valid;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [3:0]  port;
    logic [31:0] seen;
    logic [63:0] rx;
    logic [63:0] tx;
    logic [31:0] id;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_DIRECT
  } state_t;

  typedef struct packed {
    logic mac_hit;
    logic free_hit;
    logic id_hit;
    logic sweep_hit;
  } scan_t;

  typedef struct packed {
    logic        apply;
    logic        at_target;
    logic        replace;
    logic        sub;
    logic        last_flag;
    logic [31:0] next_id;
  } apply_ctrl_t;

  typedef struct packed {
    logic     emit;
    logic     hold;
    out_res_t res;
  } head_out_t;

endpackage
`default_nettype wire

// ===== rtl/stt_cell.sv =====
// one cell of the rotating entry ring: holds a single table entry
// depends on stt_pkg
`default_nettype none
module stt_cell (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             shift_en,
  input  wire stt_pkg::entry_t d,
  output stt_pkg::entry_t q
);
  import stt_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = shift_en ? d : entry_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.mac  <= entry_nxt.mac;
    entry_r.ip   <= entry_nxt.ip;
    entry_r.port <= entry_nxt.port;
    entry_r.seen <= entry_nxt.seen;
    entry_r.rx   <= entry_nxt.rx;
    entry_r.tx   <= entry_nxt.tx;
    entry_r.id   <= entry_nxt.id;
  end

  assign q = entry_r;

endmodule
`default_nettype wire

// ===== rtl/stt_head.sv =====
// head of the ring: match flags for the scan pass, entry rewrite and
// event for the apply pass; depends on stt_pkg
`default_nettype none
module stt_head (
  input  wire stt_pkg::entry_t      e,
  input  wire stt_pkg::in_req_t     req,
  input  wire [31:0]                now,
  input  wire [31:0]                ttl,
  input  wire stt_pkg::apply_ctrl_t ctrl,
  output stt_pkg::scan_t            sc,
  output stt_pkg::entry_t           nxt,
  output stt_pkg::head_out_t        ho
);
  import stt_pkg::*;

  always_comb begin
    logic [31:0] age;
    entry_t      fresh;
    age = e.seen + ttl - now;
    fresh.valid = 1'b1;
    fresh.mac   = req.mac_addr;
    fresh.ip    = req.ip_addr;
    fresh.port  = req.port;
    fresh.seen  = now;
    fresh.rx    = '0;
    fresh.tx    = '0;
    fresh.id    = ctrl.next_id;

    sc.mac_hit  = e.valid && (e.mac == req.mac_addr);
    sc.free_hit = !e.valid;
    sc.id_hit   = e.valid && (e.id == req.entry_id);
    case (req.op) inside
      OP_TICK:       sc.sweep_hit = e.valid && age[31];
      OP_FLUSH_ALL:  sc.sweep_hit = e.valid;
      OP_FLUSH_PORT: sc.sweep_hit = e.valid && (e.port == req.port);
      default:       sc.sweep_hit = 1'b0;
    endcase

    nxt     = e;
    ho.emit = 1'b0;
    ho.hold = 1'b0;
    ho.res  = '0;
    if (ctrl.apply) begin
      case (req.op) inside
        OP_CREATE: begin
          if (ctrl.at_target) begin
            nxt = fresh;
            ho.emit = 1'b1;
            if (ctrl.replace && ctrl.sub) begin
              ho.res.event_kind = EV_DEL;
              ho.res.ev_mac     = e.mac;
              ho.res.ev_ip      = e.ip;
              ho.res.ev_port    = e.port;
              ho.res.ev_id      = e.id;
              ho.res.last       = 1'b1;
            end else begin
              ho.hold           = ctrl.replace;
              ho.res.event_kind = EV_ADD;
              ho.res.ev_mac     = req.mac_addr;
              ho.res.ev_ip      = req.ip_addr;
              ho.res.ev_port    = req.port;
              ho.res.ev_id      = ctrl.next_id;
              ho.res.last       = !ctrl.replace;
            end
          end
        end
        OP_UPD_MAC: begin
          if (ctrl.at_target) begin
            if (req.alive) begin
              nxt.seen = now;
            end
            nxt.ip = req.ip_addr;
            nxt.rx = e.rx + 64'(req.rx_add);
            nxt.tx = e.tx + 64'(req.tx_add);
            if (e.ip != req.ip_addr) begin
              ho.emit           = 1'b1;
              ho.res.event_kind = EV_CHANGE;
              ho.res.ev_mac     = e.mac;
              ho.res.ev_ip      = req.ip_addr;
              ho.res.ev_port    = e.port;
              ho.res.ev_id      = e.id;
              ho.res.last       = 1'b1;
            end
          end
        end
        OP_UPD_ID: begin
          if (ctrl.at_target) begin
            nxt.seen = now;
            nxt.rx   = e.rx + 64'(req.rx_add);
            nxt.tx   = e.tx + 64'(req.tx_add);
          end
        end
        OP_TICK, OP_FLUSH_ALL, OP_FLUSH_PORT: begin
          if (sc.sweep_hit) begin
            nxt.valid         = 1'b0;
            ho.emit           = 1'b1;
            ho.res.event_kind = EV_DEL;
            ho.res.ev_mac     = e.mac;
            ho.res.ev_ip      = e.ip;
            ho.res.ev_port    = e.port;
            ho.res.ev_id      = e.id;
            ho.res.last       = ctrl.last_flag;
          end
        end
        OP_READ_SLOT: begin
          if (ctrl.at_target) begin
            ho.emit           = 1'b1;
            ho.res.event_kind = EV_READ;
            ho.res.last       = 1'b1;
            if (e.valid) begin
              ho.res.ev_mac     = e.mac;
              ho.res.ev_ip      = e.ip;
              ho.res.ev_port    = e.port;
              ho.res.ev_id      = e.id;
              ho.res.rx_total   = e.rx;
              ho.res.tx_total   = e.tx;
              ho.res.slot_valid = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/station_table_with_aging_top.sv =====
// top level of the station table with aging: ring of entry cells, head
// logic, sequencer and output register; depends on stt_pkg, stt_cell, stt_head
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | stt_pkg::in_req_t
//   out_    | output    | out_valid/out_stall| stt_pkg::out_res_t
//   cfg_    | input     | cfg_wr_en          | cfg_wr_data (ttl_ticks)
//
// a request that updates, reports or removes an entry passes the accept state,
// a scan turn of the ring, then an apply turn
// a request with nothing to apply ends after the scan turn;
// a create into a full table sends its full event from a direct state after the scan turn
// out_stall holds the apply turn at a slot with an event; a create that
// replaces an entry stays at that slot to send its add event, then a delete event
// reset clears the valid bits, time and serial, and sets ttl to 60
`default_nettype none
module station_table_with_aging_top (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire stt_pkg::in_req_t   in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output stt_pkg::out_res_t       out_data,
  input  wire                     cfg_wr_en,
  input  wire [31:0]              cfg_wr_data
);
  import stt_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  entry_t      cell_q [ENTRIES];
  entry_t      head_nxt;
  scan_t       sc;
  head_out_t   ho;
  apply_ctrl_t ctrl;
  logic        shift;
  logic        can_load;
  logic        load_out;
  out_res_t    res_sel;
  out_res_t    direct_res;

  state_t           state_r,     state_nxt;
  in_req_t          req_r,       req_nxt;
  logic [IDX_W-1:0] cnt_r,       cnt_nxt;
  logic [31:0]      now_r,       now_nxt;
  logic [31:0]      serial_r,    serial_nxt;
  logic [31:0]      ttl_r,       ttl_nxt;
  logic             found_r,     found_nxt;
  logic [IDX_W-1:0] found_idx_r, found_idx_nxt;
  logic             fpm_r,       fpm_nxt;
  logic             free_r,      free_nxt;
  logic [IDX_W-1:0] free_idx_r,  free_idx_nxt;
  logic             idm_r,       idm_nxt;
  logic [IDX_W-1:0] idm_idx_r,   idm_idx_nxt;
  logic [CNT_W-1:0] sw_cnt_r,    sw_cnt_nxt;
  logic [CNT_W-1:0] remain_r,    remain_nxt;
  logic [IDX_W-1:0] target_r,    target_nxt;
  logic             replace_r,   replace_nxt;
  logic             sub_r,       sub_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_res_t         out_data_r,  out_data_nxt;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == ENTRIES - 1) begin : g_tail
      stt_cell u_cell (.clk(clk), .rst_n(rst_n), .shift_en(shift), .d(head_nxt),
                       .q(cell_q[i]));
    end else begin : g_mid
      stt_cell u_cell (.clk(clk), .rst_n(rst_n), .shift_en(shift), .d(cell_q[i+1]),
                       .q(cell_q[i]));
    end
  end

  stt_head u_head (
    .e    (cell_q[0]),
    .req  (req_r),
    .now  (now_r),
    .ttl  (ttl_r),
    .ctrl (ctrl),
    .sc   (sc),
    .nxt  (head_nxt),
    .ho   (ho)
  );

  assign can_load  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    direct_res = '0;
    direct_res.last = 1'b1;
    if (req_r.op == OP_CREATE) begin
      direct_res.event_kind = EV_FULL;
      direct_res.ev_mac     = req_r.mac_addr;
      direct_res.ev_ip      = req_r.ip_addr;
      direct_res.ev_port    = req_r.port;
    end else begin
      direct_res.event_kind = EV_READ;
    end
  end

  always_comb begin
    logic             f_found, f_pm, f_free, f_idm;
    logic [IDX_W-1:0] f_idx, f_free_idx, f_idm_idx;
    logic [CNT_W-1:0] f_cnt;

    state_nxt     = state_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    now_nxt       = now_r;
    serial_nxt    = serial_r;
    ttl_nxt       = cfg_wr_en ? cfg_wr_data : ttl_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    fpm_nxt       = fpm_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    idm_nxt       = idm_r;
    idm_idx_nxt   = idm_idx_r;
    sw_cnt_nxt    = sw_cnt_r;
    remain_nxt    = remain_r;
    target_nxt    = target_r;
    replace_nxt   = replace_r;
    sub_nxt       = sub_r;
    shift         = 1'b0;
    load_out      = 1'b0;
    res_sel       = ho.res;

    ctrl.apply     = (state_r == ST_APPLY);
    ctrl.at_target = (cnt_r == target_r);
    ctrl.replace   = replace_r;
    ctrl.sub       = sub_r;
    ctrl.last_flag = (remain_r == CNT_W'(1));
    // serial already advanced by the add event when the old entry is retired
    ctrl.next_id   = sub_r ? serial_r : serial_r + 32'd1;

    f_found    = found_r | sc.mac_hit;
    f_idx      = found_r ? found_idx_r : cnt_r;
    f_pm       = found_r ? fpm_r : (cell_q[0].port == req_r.port);
    f_free     = free_r | sc.free_hit;
    f_free_idx = free_r ? free_idx_r : cnt_r;
    f_idm      = idm_r | sc.id_hit;
    f_idm_idx  = idm_r ? idm_idx_r : cnt_r;
    f_cnt      = sw_cnt_r + CNT_W'(sc.sweep_hit);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          state_nxt  = ST_SCAN;
          cnt_nxt    = '0;
          found_nxt  = 1'b0;
          free_nxt   = 1'b0;
          idm_nxt    = 1'b0;
          sw_cnt_nxt = '0;
          sub_nxt    = 1'b0;
          if (in_data.op == OP_TICK) begin
            now_nxt = now_r + 32'd1;
          end
        end
      end
      ST_SCAN: begin
        shift         = 1'b1;
        found_nxt     = f_found;
        found_idx_nxt = f_idx;
        fpm_nxt       = f_pm;
        free_nxt      = f_free;
        free_idx_nxt  = f_free_idx;
        idm_nxt       = f_idm;
        idm_idx_nxt   = f_idm_idx;
        sw_cnt_nxt    = f_cnt;
        cnt_nxt       = cnt_r + IDX_W'(1);
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
          case (req_r.op) inside
            OP_CREATE: begin
              if (32'(req_r.port) >= 32'(PORTS) || (f_found && f_pm)) begin
                state_nxt = ST_IDLE;
              end else if (!f_found && !f_free) begin
                state_nxt = ST_DIRECT;
              end else begin
                state_nxt   = ST_APPLY;
                target_nxt  = f_found ? f_idx : f_free_idx;
                replace_nxt = f_found;
              end
            end
            OP_UPD_MAC: begin
              if (f_found) begin
                state_nxt  = ST_APPLY;
                target_nxt = f_idx;
              end
            end
            OP_UPD_ID: begin
              if (f_idm) begin
                state_nxt  = ST_APPLY;
                target_nxt = f_idm_idx;
              end
            end
            OP_TICK, OP_FLUSH_ALL, OP_FLUSH_PORT: begin
              if (f_cnt != '0) begin
                state_nxt  = ST_APPLY;
                remain_nxt = f_cnt;
              end
            end
            OP_READ_SLOT: begin
              if (32'(req_r.slot) < 32'(ENTRIES)) begin
                state_nxt  = ST_APPLY;
                target_nxt = IDX_W'(req_r.slot);
              end else begin
                state_nxt = ST_DIRECT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_APPLY: begin
        if (!ho.emit || can_load) begin
          if (ho.emit) begin
            load_out   = 1'b1;
            remain_nxt = remain_r - CNT_W'(1);
            if (ho.res.event_kind == EV_ADD) begin
              serial_nxt = serial_r + 32'd1;
            end
          end
          if (ho.hold) begin
            sub_nxt = 1'b1;
          end else begin
            shift   = 1'b1;
            sub_nxt = 1'b0;
            cnt_nxt = cnt_r + IDX_W'(1);
            if (cnt_r == LAST_IDX) begin
              cnt_nxt   = '0;
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_DIRECT: begin
        res_sel = direct_res;
        if (can_load) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_data_nxt  = load_out ? res_sel : out_data_r;
    out_valid_nxt = load_out ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      now_r       <= '0;
      serial_r    <= '0;
      ttl_r       <= 32'd60;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      idm_r       <= 1'b0;
      sw_cnt_r    <= '0;
      remain_r    <= '0;
      replace_r   <= 1'b0;
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      now_r       <= now_nxt;
      serial_r    <= serial_nxt;
      ttl_r       <= ttl_nxt;
      found_r     <= found_nxt;
      free_r      <= free_nxt;
      idm_r       <= idm_nxt;
      sw_cnt_r    <= sw_cnt_nxt;
      remain_r    <= remain_nxt;
      replace_r   <= replace_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r       <= req_nxt;
    found_idx_r <= found_idx_nxt;
    fpm_r       <= fpm_nxt;
    free_idx_r  <= free_idx_nxt;
    idm_idx_r   <= idm_idx_nxt;
    target_r    <= target_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/stt_checker.sv =====
// port-level checker for the station table, bound to the top level
// depends on stt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module stt_props (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_valid,
  input wire                    in_stall,
  input wire                    out_valid,
  input wire                    out_stall,
  input wire stt_pkg::out_res_t out_data
);
  import stt_pkg::*;

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped")
  `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "result changed")
  `ASSERT_CLK(a_busy_after_req, clk, rst_n, in_valid && !in_stall |=> in_stall, "request not held off")
  `ASSERT_CLK(a_slot_valid_kind, clk, rst_n, out_valid && out_data.slot_valid |-> out_data.event_kind == EV_READ, "slot_valid off readback")
  `ASSERT_CLK(a_totals_zero, clk, rst_n, out_valid && (out_data.event_kind != EV_READ) |-> (out_data.rx_total == 64'd0) && (out_data.tx_total == 64'd0), "counters outside readback")

endmodule

bind station_table_with_aging_top stt_props u_stt_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ===== test/stt_checker.sv =====
// checker for the station table: watches request, result and config ports,
// predicts the events of each request and compares them; depends on stt_pkg
module stt_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_stall,
  input  stt_pkg::in_req_t  in_data,
  input  wire               out_valid,
  input  wire               out_stall,
  input  stt_pkg::out_res_t out_data,
  input  wire               cfg_wr_en,
  input  wire [31:0]        cfg_wr_data,
  output int                fail_count,
  output int                pending,
  output int                event_count
);
  import stt_pkg::*;

  logic        m_valid [ENTRIES];
  logic [47:0] m_mac   [ENTRIES];
  logic [31:0] m_ip    [ENTRIES];
  logic [3:0]  m_port  [ENTRIES];
  logic [31:0] m_seen  [ENTRIES];
  logic [63:0] m_rx    [ENTRIES];
  logic [63:0] m_tx    [ENTRIES];
  logic [31:0] m_id    [ENTRIES];
  logic [31:0] m_now, m_serial, m_ttl;
  out_res_t    event_q [$];

  function automatic out_res_t mk(logic [2:0] k, logic [47:0] mac, logic [31:0] ip,
                                  logic [3:0] p, logic [31:0] id);
    out_res_t r;
    r = '0;
    r.event_kind = k; r.ev_mac = mac; r.ev_ip = ip; r.ev_port = p; r.ev_id = id;
    return r;
  endfunction

  task automatic report(string what, out_res_t got, out_res_t exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    fail_count++;
  endtask

  task automatic predict_events(in_req_t rq);
    out_res_t ev [$];
    out_res_t r;
    int s;
    logic [31:0] d;
    s = -1;
    case (rq.op)
      OP_CREATE: begin
        for (int i = 0; i < ENTRIES; i++)
          if (s < 0 && m_valid[i] && m_mac[i] == rq.mac_addr) s = i;
        if (!(s >= 0 && m_port[s] == rq.port)) begin
          if (s < 0) begin
            for (int i = 0; i < ENTRIES; i++)
              if (s < 0 && !m_valid[i]) s = i;
            if (s < 0) ev.push_back(mk(EV_FULL, rq.mac_addr, rq.ip_addr, rq.port, 0));
            else begin
              m_serial++;
              ev.push_back(mk(EV_ADD, rq.mac_addr, rq.ip_addr, rq.port, m_serial));
            end
          end else begin
            m_serial++;
            ev.push_back(mk(EV_ADD, rq.mac_addr, rq.ip_addr, rq.port, m_serial));
            ev.push_back(mk(EV_DEL, m_mac[s], m_ip[s], m_port[s], m_id[s]));
          end
          if (s >= 0) begin
            m_valid[s] = 1; m_mac[s] = rq.mac_addr; m_ip[s] = rq.ip_addr;
            m_port[s] = rq.port; m_seen[s] = m_now; m_rx[s] = 0; m_tx[s] = 0;
            m_id[s] = m_serial;
          end
        end
      end
      OP_UPD_MAC: begin
        for (int i = 0; i < ENTRIES; i++)
          if (s < 0 && m_valid[i] && m_mac[i] == rq.mac_addr) s = i;
        if (s >= 0) begin
          if (rq.alive) m_seen[s] = m_now;
          if (m_ip[s] != rq.ip_addr) begin
            m_ip[s] = rq.ip_addr;
            ev.push_back(mk(EV_CHANGE, m_mac[s], m_ip[s], m_port[s], m_id[s]));
          end
          m_rx[s] += 64'(rq.rx_add); m_tx[s] += 64'(rq.tx_add);
        end
      end
      OP_UPD_ID: begin
        for (int i = 0; i < ENTRIES; i++)
          if (s < 0 && m_valid[i] && m_id[i] == rq.entry_id) begin
            s = i; m_seen[i] = m_now;
            m_rx[i] += 64'(rq.rx_add); m_tx[i] += 64'(rq.tx_add);
          end
      end
      OP_TICK: begin
        m_now++;
        for (int i = 0; i < ENTRIES; i++) begin
          d = m_seen[i] + m_ttl - m_now;
          if (m_valid[i] && d[31]) begin
            ev.push_back(mk(EV_DEL, m_mac[i], m_ip[i], m_port[i], m_id[i]));
            m_valid[i] = 0;
          end
        end
      end
      OP_FLUSH_ALL, OP_FLUSH_PORT: begin
        for (int i = 0; i < ENTRIES; i++)
          if (m_valid[i] && (rq.op == OP_FLUSH_ALL || m_port[i] == rq.port)) begin
            ev.push_back(mk(EV_DEL, m_mac[i], m_ip[i], m_port[i], m_id[i]));
            m_valid[i] = 0;
          end
      end
      OP_READ_SLOT: begin
        if (rq.slot < ENTRIES && m_valid[rq.slot]) begin
          r = mk(EV_READ, m_mac[rq.slot], m_ip[rq.slot], m_port[rq.slot], m_id[rq.slot]);
          r.rx_total = m_rx[rq.slot]; r.tx_total = m_tx[rq.slot]; r.slot_valid = 1;
        end else r = mk(EV_READ, 0, 0, 0, 0);
        ev.push_back(r);
      end
      default: ;
    endcase
    if (ev.size() > 0) ev[ev.size()-1].last = 1;
    foreach (ev[k]) event_q.push_back(ev[k]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        m_valid[i] = 0; m_mac[i] = 0; m_ip[i] = 0; m_port[i] = 0;
        m_seen[i] = 0; m_rx[i] = 0; m_tx[i] = 0; m_id[i] = 0;
      end
      m_now = 0; m_serial = 0; m_ttl = 60;
      fail_count = 0; event_count = 0;
      event_q.delete();
      pending = 0;
    end else begin
      if (cfg_wr_en) m_ttl = cfg_wr_data;
      if (out_valid && !out_stall) begin
        event_count++;
        if (event_q.size() == 0) report("unexpected result", out_data, '0);
        else begin
          if (out_data.event_kind !== event_q[0].event_kind) report("kind", out_data, event_q[0]);
          else if (out_data.ev_mac !== event_q[0].ev_mac) report("mac", out_data, event_q[0]);
          else if (out_data.ev_ip !== event_q[0].ev_ip) report("ip", out_data, event_q[0]);
          else if (out_data.ev_port !== event_q[0].ev_port) report("port", out_data, event_q[0]);
          else if (out_data.ev_id !== event_q[0].ev_id) report("id", out_data, event_q[0]);
          else if (out_data.rx_total !== event_q[0].rx_total) report("rx", out_data, event_q[0]);
          else if (out_data.tx_total !== event_q[0].tx_total) report("tx", out_data, event_q[0]);
          else if (out_data.slot_valid !== event_q[0].slot_valid)
            report("slot_valid", out_data, event_q[0]);
          else if (out_data.last !== event_q[0].last) report("last", out_data, event_q[0]);
          void'(event_q.pop_front());
        end
      end
      if (in_valid && !in_stall) predict_events(in_data);
      pending = event_q.size();
    end
  end
endmodule

// ===== test/tb.sv =====
// testbench top for the station table: clock, reset, request and config
// stimulus with idle and output stall phases, verdict; depends on stt_pkg, stt_checker, rtl
module tb;
  import stt_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall, cfg_wr_en;
  in_req_t   in_data;
  out_res_t  out_data;
  logic [31:0] cfg_wr_data;
  int fail_count, pending, event_count, cycles, sent;
  int idle_pct, stall_pct;
  logic [47:0] mac_pool [8];
  logic [31:0] ip_pool [4];

  station_table_with_aging_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  stt_checker i_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending), .event_count(event_count)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= ($urandom_range(99) < stall_pct);
    if (cycles > 900000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(in_req_t rq);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    in_valid <= 1;
    in_data <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 0;
    sent++;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic set_ttl(logic [31:0] v);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  function automatic in_req_t rand_req(bit pooled);
    in_req_t rq;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    rq = raw[$bits(in_req_t)-1:0];
    if (pooled) begin
      rq.op = 3'($urandom_range(6));
      if (rq.op == OP_CREATE && $urandom_range(3) != 0) rq.op = OP_CREATE;
      rq.mac_addr = mac_pool[$urandom_range(7)];
      rq.ip_addr = ip_pool[$urandom_range(3)];
      rq.port = 4'($urandom_range(3));
      rq.entry_id = $urandom_range(40);
      if (rq.op == OP_FLUSH_ALL && $urandom_range(3) != 0) rq.op = OP_CREATE;
    end
    return rq;
  endfunction

  function automatic in_req_t req(logic [2:0] op, logic [47:0] mac, logic [31:0] ip,
                                  logic [3:0] p);
    in_req_t rq;
    rq = '0;
    rq.op = op; rq.mac_addr = mac; rq.ip_addr = ip; rq.port = p;
    return rq;
  endfunction

  initial begin
    in_req_t rq;
    rst_n = 0; in_valid = 0; in_data = '0; out_stall = 0;
    cfg_wr_en = 0; cfg_wr_data = 0; cycles = 0; sent = 0;
    idle_pct = 0; stall_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    send(req(OP_CREATE, '1, '1, 4'hf));
    send(req(OP_CREATE, '0, '0, 4'h0));
    send(req(OP_CREATE, '0, 32'h1, 4'h0));
    send(req(OP_CREATE, '0, 32'h2, 4'h3));
    rq = req(OP_UPD_MAC, '1, 32'h5, 0); rq.rx_add = '1; rq.tx_add = '1; rq.alive = 1;
    send(rq); send(rq);
    rq = req(OP_UPD_ID, 0, 0, 0); rq.entry_id = 1; rq.rx_add = '1; send(rq);
    rq.entry_id = '1; send(rq);
    rq = req(OP_READ_SLOT, 0, 0, 0); send(rq);
    rq.slot = 1; send(rq);
    rq.slot = 5'd31; send(rq);
    send(req(OP_UNUSED, 0, 0, 0));
    send(req(OP_FLUSH_PORT, 0, 0, 4'h3));
    send(req(OP_FLUSH_PORT, 0, 0, 4'hf));
    set_ttl(1);
    send(req(OP_CREATE, 48'h1234, 1, 1));
    send(req(OP_TICK, 0, 0, 0)); send(req(OP_TICK, 0, 0, 0)); send(req(OP_TICK, 0, 0, 0));
    for (int i = 0; i < 33; i++) send(req(OP_CREATE, 48'(i + 100), i, i[3:0]));
    send(req(OP_FLUSH_ALL, 0, 0, 0));
    set_ttl(0);
    send(req(OP_CREATE, 48'h77, 7, 2));
    send(req(OP_TICK, 0, 0, 0));
    set_ttl('1);
    for (int i = 0; i < 8; i++) mac_pool[i] = (i == 7) ? '1 : {$urandom, $urandom};
    for (int i = 0; i < 4; i++) ip_pool[i] = $urandom;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 64; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 64; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      if (ph == 4) set_ttl(3);
      if (ph == 6) set_ttl(60);
      for (int k = 0; k < 53; k++) begin
        if (k == 30) while (pending != 0) @(posedge clk);
        send(rand_req($urandom_range(9) != 0));
      end
    end
    idle_pct = 0; stall_pct = 0;
    drain();
    $display("sent %0d requests, checked %0d events over ttl settings 60,1,0,max,3",
             sent, event_count);
    if (fail_count == 0 && pending == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== station_table_with_aging_top.f =====
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_cell.sv
rtl/stt_head.sv
rtl/station_table_with_aging_top.sv
rtl/stt_checker.sv
test/stt_checker.sv
test/tb.sv
